// ===== design/pfs_pkg.sv =====
`default_nettype none

package pfs_pkg;

    // Parameter defaults
    localparam int DEF_COUNT_BITS = 32;
    localparam int DEF_MAX_FRAME  = 8192;

    // Field widths
    localparam int FRAME_LEN_W = 14;
    localparam int MAC_W       = 48;
    localparam int ETYPE_W     = 16;
    localparam int IP_W        = 32;
    localparam int PROTO_W     = 8;
    localparam int LEN_W       = 16;
    localparam int PORT_W      = 16;
    localparam int ICMP_W      = 8;
    localparam int SEL_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int WIDE_W      = 64;
    localparam int MASK_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Counter bank
    localparam int NUM_COUNTERS = 14;
    localparam int C_FRAMES  = 0;
    localparam int C_BYTES   = 1;
    localparam int C_SHORT   = 2;
    localparam int C_LONG    = 3;
    localparam int C_MACBC   = 4;
    localparam int C_IPPKT   = 5;
    localparam int C_IPBYTE  = 6;
    localparam int C_IPBC    = 7;
    localparam int C_ICMP    = 8;
    localparam int C_REDIR   = 9;
    localparam int C_UNREACH = 10;
    localparam int C_TCP     = 11;
    localparam int C_UDP     = 12;
    localparam int C_ARP     = 13;

    // Display mask bits
    localparam int M_ETHER = 0;
    localparam int M_ARP   = 1;
    localparam int M_IP    = 2;
    localparam int M_TCP   = 3;
    localparam int M_UDP   = 4;
    localparam int M_ICMP  = 5;
    localparam int M_ALL   = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_ON      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_VALUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_VALUE   = 3'd4;

    // Commands
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Protocol codes
    localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
    localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;
    localparam logic [ICMP_W-1:0]  ICMP_UNREACH    = 8'd3;
    localparam logic [ICMP_W-1:0]  ICMP_REDIR_KIND = 8'd5;

    // Frame size limits
    localparam logic [LEN_W-1:0] SHORT_LEN = 16'd64;
    localparam logic [LEN_W-1:0] LONG_LEN  = 16'd1518;

    typedef struct packed {
        logic                   command;
        logic [FRAME_LEN_W-1:0] frame_len;
        logic [MAC_W-1:0]       dest_mac;
        logic [ETYPE_W-1:0]     ether_kind;
        logic [IP_W-1:0]        source_ip;
        logic [IP_W-1:0]        dest_ip;
        logic [PROTO_W-1:0]     ip_protocol;
        logic [LEN_W-1:0]       ip_length;
        logic [PORT_W-1:0]      source_port;
        logic [PORT_W-1:0]      dest_port;
        logic [ICMP_W-1:0]      icmp_kind;
        logic [SEL_W-1:0]       counter_select;
    } pfs_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] display_mask;
        logic              addr_on;
        logic [IP_W-1:0]   addr_value;
        logic              port_on;
        logic [PORT_W-1:0] port_value;
    } pfs_cfg_t;

    typedef struct packed {
        logic [NUM_COUNTERS-1:0] bump;
        logic [LEN_W-1:0]        frame_bytes;
        logic [LEN_W-1:0]        ip_bytes;
    } pfs_update_t;

endpackage

`default_nettype wire

// ===== design/pfs_classify.sv =====
`default_nettype none

// Header classification and filter decision, purely combinational.
module pfs_classify #(
    parameter int MAX_FRAME = pfs_pkg::DEF_MAX_FRAME
) (
    input  var pfs_pkg::pfs_item_t   item,
    input  var pfs_pkg::pfs_cfg_t    cfg,
    output pfs_pkg::pfs_update_t     upd,
    output logic                     show,
    output logic                     filtered
);

    localparam logic [pfs_pkg::LEN_W-1:0] MAX_LEN = pfs_pkg::LEN_W'(MAX_FRAME);

    logic [pfs_pkg::LEN_W-1:0] raw_len;
    logic [pfs_pkg::LEN_W-1:0] len;
    logic addr_ok, port_ok;
    logic is_arp, is_ip, is_tcp, is_udp, is_icmp, is_other;
    logic rejected, disp;
    logic [pfs_pkg::MASK_W-1:0] m;

    assign m       = cfg.display_mask;
    assign raw_len = pfs_pkg::LEN_W'(item.frame_len);
    assign len     = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;

    assign addr_ok = !cfg.addr_on || (item.source_ip == cfg.addr_value)
                     || (item.dest_ip == cfg.addr_value);
    assign port_ok = !cfg.port_on || (item.source_port == cfg.port_value)
                     || (item.dest_port == cfg.port_value);

    assign is_arp   = (item.ether_kind == pfs_pkg::ETYPE_ARP);
    assign is_ip    = (item.ether_kind == pfs_pkg::ETYPE_IPV4);
    // L4 classes only count once the address filter passes
    assign is_tcp   = is_ip && addr_ok && (item.ip_protocol == pfs_pkg::PROTO_TCP);
    assign is_udp   = is_ip && addr_ok && (item.ip_protocol == pfs_pkg::PROTO_UDP);
    assign is_icmp  = is_ip && addr_ok && (item.ip_protocol == pfs_pkg::PROTO_ICMP);
    assign is_other = is_ip && addr_ok && !is_tcp && !is_udp && !is_icmp;

    always_comb begin
        upd = '0;
        upd.frame_bytes = len;
        upd.ip_bytes    = item.ip_length;
        upd.bump[pfs_pkg::C_FRAMES]  = 1'b1;
        upd.bump[pfs_pkg::C_BYTES]   = 1'b1;
        upd.bump[pfs_pkg::C_SHORT]   = (len < pfs_pkg::SHORT_LEN);
        upd.bump[pfs_pkg::C_LONG]    = (len > pfs_pkg::LONG_LEN);
        upd.bump[pfs_pkg::C_MACBC]   = &item.dest_mac;
        upd.bump[pfs_pkg::C_ARP]     = is_arp;
        upd.bump[pfs_pkg::C_IPPKT]   = is_ip;
        upd.bump[pfs_pkg::C_IPBYTE]  = is_ip;
        upd.bump[pfs_pkg::C_IPBC]    = is_ip && (&item.dest_ip);
        upd.bump[pfs_pkg::C_TCP]     = is_tcp;
        upd.bump[pfs_pkg::C_UDP]     = is_udp;
        upd.bump[pfs_pkg::C_ICMP]    = is_icmp;
        upd.bump[pfs_pkg::C_REDIR]   = is_icmp
                                       && (item.icmp_kind == pfs_pkg::ICMP_REDIR_KIND);
        upd.bump[pfs_pkg::C_UNREACH] = is_icmp && (item.icmp_kind == pfs_pkg::ICMP_UNREACH);
    end

    assign rejected = is_ip && (!addr_ok || ((is_tcp || is_udp) && !port_ok));

    always_comb begin
        disp = m[pfs_pkg::M_ETHER];
        if (is_arp) begin
            disp = disp | (m[pfs_pkg::M_ARP] & addr_ok);
        end else if (is_ip) begin
            if (addr_ok) begin
                disp = disp | (m[pfs_pkg::M_IP] & !(m[pfs_pkg::M_TCP] | m[pfs_pkg::M_UDP]
                                                    | m[pfs_pkg::M_ICMP]));
            end
            disp = disp | (is_tcp & port_ok & m[pfs_pkg::M_TCP])
                        | (is_udp & port_ok & m[pfs_pkg::M_UDP])
                        | (is_icmp & m[pfs_pkg::M_ICMP])
                        | (is_other & m[pfs_pkg::M_ALL]);
        end else begin
            disp = disp | (m[pfs_pkg::M_ETHER] & m[pfs_pkg::M_ALL]);
        end
    end

    assign show     = !rejected && (disp || m[pfs_pkg::M_ALL]);
    assign filtered = rejected;

endmodule

`default_nettype wire

// ===== design/pfs_counters.sv =====
`default_nettype none

// Statistics counter bank: parallel increment, one read port.
module pfs_counters #(
    parameter int COUNT_BITS = pfs_pkg::DEF_COUNT_BITS
) (
    input  var logic                        aclk,
    input  var logic                        aresetn,
    input  var logic                        upd_en,
    input  var pfs_pkg::pfs_update_t        upd,
    input  var logic [pfs_pkg::SEL_W-1:0]   rd_sel,
    output logic [pfs_pkg::VALUE_W-1:0]     rd_value
);

    logic [COUNT_BITS-1:0] cnt_reg  [pfs_pkg::NUM_COUNTERS];
    logic [COUNT_BITS-1:0] cnt_next [pfs_pkg::NUM_COUNTERS];
    logic [COUNT_BITS-1:0] step_amt [pfs_pkg::NUM_COUNTERS];
    logic [pfs_pkg::WIDE_W-1:0] rd_wide;

    always_comb begin
        for (int i = 0; i < pfs_pkg::NUM_COUNTERS; i++) begin
            step_amt[i] = COUNT_BITS'(1);
        end
        step_amt[pfs_pkg::C_BYTES]  = COUNT_BITS'(upd.frame_bytes);
        step_amt[pfs_pkg::C_IPBYTE] = COUNT_BITS'(upd.ip_bytes);
        for (int i = 0; i < pfs_pkg::NUM_COUNTERS; i++) begin
            cnt_next[i] = cnt_reg[i];
            if (upd_en && upd.bump[i]) begin
                cnt_next[i] = cnt_reg[i] + step_amt[i];   // wraps
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pfs_pkg::NUM_COUNTERS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < pfs_pkg::NUM_COUNTERS; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Low word of the selected counter; unused selects read zero
    always_comb begin
        rd_wide = '0;
        if (rd_sel < pfs_pkg::SEL_W'(pfs_pkg::NUM_COUNTERS)) begin
            rd_wide = pfs_pkg::WIDE_W'(cnt_reg[rd_sel]);
        end
    end
    assign rd_value = rd_wide[pfs_pkg::VALUE_W-1:0];

    a_frames_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |=> cnt_reg[pfs_pkg::C_FRAMES]
                   == $past(cnt_reg[pfs_pkg::C_FRAMES]) + COUNT_BITS'(1))
        else $error("frame counter did not advance by one");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd_en |=> $stable(cnt_reg[pfs_pkg::C_FRAMES]) && $stable(cnt_reg[pfs_pkg::C_BYTES])
                    && $stable(cnt_reg[pfs_pkg::C_IPBYTE]))
        else $error("counters changed without a packet");

    a_bad_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_sel >= pfs_pkg::SEL_W'(pfs_pkg::NUM_COUNTERS)) |-> (rd_value == '0))
        else $error("unused counter select read nonzero");

endmodule

`default_nettype wire

// ===== design/packet_filter_statistics.sv =====
`default_nettype none

// Channel  | Direction | Ports                                  | Transfer when
// ---------+-----------+----------------------------------------+---------------------------
// s_       | in        | s_valid, s_ready, s_<header fields>    | s_valid && s_ready
// m_       | out       | m_valid, m_ready, m_<result fields>    | m_valid && m_ready
// cfg_     | in        | cfg_valid, cfg_ready, cfg_index/data   | cfg_valid && cfg_ready
//
// Flow: one item per clock sustained while m_ready stays high; input register,
//   then classify + counter update into the result register.
// Counters update on the edge where an item leaves the input register, so a
//   read right behind a packet already sees that packet's counts.
// Reset (aresetn low, synchronous) clears counters, config and valid flags.
// Stalls: a held result backs up into the input register; s_ready drops only
//   when both stages are full and m_ready is low. cfg_ready is always high.
module packet_filter_statistics #(
    parameter int COUNT_BITS = pfs_pkg::DEF_COUNT_BITS,
    parameter int MAX_FRAME  = pfs_pkg::DEF_MAX_FRAME
) (
    input  var logic                              aclk,
    input  var logic                              aresetn,

    input  var logic                              s_valid,
    output logic                                  s_ready,
    input  var logic                              s_command,
    input  var logic [pfs_pkg::FRAME_LEN_W-1:0]   s_frame_len,
    input  var logic [pfs_pkg::MAC_W-1:0]         s_dest_mac,
    input  var logic [pfs_pkg::ETYPE_W-1:0]       s_ether_kind,
    input  var logic [pfs_pkg::IP_W-1:0]          s_source_ip,
    input  var logic [pfs_pkg::IP_W-1:0]          s_dest_ip,
    input  var logic [pfs_pkg::PROTO_W-1:0]       s_ip_protocol,
    input  var logic [pfs_pkg::LEN_W-1:0]         s_ip_length,
    input  var logic [pfs_pkg::PORT_W-1:0]        s_source_port,
    input  var logic [pfs_pkg::PORT_W-1:0]        s_dest_port,
    input  var logic [pfs_pkg::ICMP_W-1:0]        s_icmp_kind,
    input  var logic [pfs_pkg::SEL_W-1:0]         s_counter_select,

    output logic                                  m_valid,
    input  var logic                              m_ready,
    output logic                                  m_show_packet,
    output logic                                  m_filtered_out,
    output logic [pfs_pkg::VALUE_W-1:0]           m_counter_value,

    input  var logic                              cfg_valid,
    output logic                                  cfg_ready,
    input  var logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  var logic [pfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Input stage
    logic                 in_valid_reg, in_valid_next;
    pfs_pkg::pfs_item_t   in_item_reg, in_item_next;

    // Result stage
    logic                        out_valid_reg, out_valid_next;
    logic                        show_reg, show_next;
    logic                        filtered_reg, filtered_next;
    logic [pfs_pkg::VALUE_W-1:0] value_reg, value_next;

    // Configuration
    pfs_pkg::pfs_cfg_t cfg_reg, cfg_next;

    logic                        advance;
    logic                        s_xfer;
    logic                        is_read;
    pfs_pkg::pfs_update_t        upd;
    logic                        cls_show, cls_filtered;
    logic [pfs_pkg::VALUE_W-1:0] rd_value;

    // Stage 1 moves on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign is_read   = (in_item_reg.command == pfs_pkg::CMD_READ);

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_xfer) begin
            in_valid_next               = 1'b1;
            in_item_next.command        = s_command;
            in_item_next.frame_len      = s_frame_len;
            in_item_next.dest_mac       = s_dest_mac;
            in_item_next.ether_kind     = s_ether_kind;
            in_item_next.source_ip      = s_source_ip;
            in_item_next.dest_ip        = s_dest_ip;
            in_item_next.ip_protocol    = s_ip_protocol;
            in_item_next.ip_length      = s_ip_length;
            in_item_next.source_port    = s_source_port;
            in_item_next.dest_port      = s_dest_port;
            in_item_next.icmp_kind      = s_icmp_kind;
            in_item_next.counter_select = s_counter_select;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    pfs_classify #(
        .MAX_FRAME (MAX_FRAME)
    ) u_classify (
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .upd      (upd),
        .show     (cls_show),
        .filtered (cls_filtered)
    );

    pfs_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd_en   (advance && !is_read),
        .upd      (upd),
        .rd_sel   (in_item_reg.counter_select),
        .rd_value (rd_value)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        show_next      = show_reg;
        filtered_next  = filtered_reg;
        value_next     = value_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            if (is_read) begin
                // read: flags low, counter word out
                show_next     = 1'b0;
                filtered_next = 1'b0;
                value_next    = rd_value;
            end else begin
                show_next     = cls_show;
                filtered_next = cls_filtered;
                value_next    = '0;
            end
        end
    end

    // Config writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                pfs_pkg::CFG_DISPLAY_MASK: begin
                    cfg_next.display_mask = cfg_data[pfs_pkg::MASK_W-1:0];
                end
                pfs_pkg::CFG_ADDR_ON: begin
                    cfg_next.addr_on = cfg_data[0];
                end
                pfs_pkg::CFG_ADDR_VALUE: begin
                    cfg_next.addr_value = cfg_data[pfs_pkg::IP_W-1:0];
                end
                pfs_pkg::CFG_PORT_ON: begin
                    cfg_next.port_on = cfg_data[0];
                end
                pfs_pkg::CFG_PORT_VALUE: begin
                    cfg_next.port_value = cfg_data[pfs_pkg::PORT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        show_reg     <= show_next;
        filtered_reg <= filtered_next;
        value_reg    <= value_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_show_packet   = show_reg;
    assign m_filtered_out  = filtered_reg;
    assign m_counter_value = value_reg;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(show_reg && filtered_reg))
        else $error("rejected packet marked as shown");

    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> in_valid_reg)
        else $error("accepted item lost from input register");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled item dropped or changed");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_read) |=> (value_reg == '0))
        else $error("packet result carries a counter value");

endmodule

`default_nettype wire

// ===== dv/packet_filter_statistics_test.sv =====
`default_nettype none

// Packet classifier / statistics counter test.
// A local model of the counter bank and the filter/display logic predicts the
// result of every accepted command; counter contents are checked through the
// block's own read command. Directed tests cover frame size boundaries, each
// protocol branch and each filter outcome, then randomized traffic runs under
// a series of register settings with random input gaps and result backpressure.
module packet_filter_statistics_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 115;
    localparam int RAND_PHASES  = 10;
    localparam int DRAIN_CYCLES = 4;    // pipeline is two deep

    typedef struct packed {
        logic                        show;
        logic                        filtered;
        logic [pfs_pkg::VALUE_W-1:0] value;
    } verdict_t;

    // Clock / reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // DUT ports, all known from time zero
    logic                            s_valid          = 1'b0;
    logic                            s_ready;
    logic                            s_command        = pfs_pkg::CMD_PACKET;
    logic [pfs_pkg::FRAME_LEN_W-1:0] s_frame_len      = '0;
    logic [pfs_pkg::MAC_W-1:0]       s_dest_mac       = '0;
    logic [pfs_pkg::ETYPE_W-1:0]     s_ether_kind     = '0;
    logic [pfs_pkg::IP_W-1:0]        s_source_ip      = '0;
    logic [pfs_pkg::IP_W-1:0]        s_dest_ip        = '0;
    logic [pfs_pkg::PROTO_W-1:0]     s_ip_protocol    = '0;
    logic [pfs_pkg::LEN_W-1:0]       s_ip_length      = '0;
    logic [pfs_pkg::PORT_W-1:0]      s_source_port    = '0;
    logic [pfs_pkg::PORT_W-1:0]      s_dest_port      = '0;
    logic [pfs_pkg::ICMP_W-1:0]      s_icmp_kind      = '0;
    logic [pfs_pkg::SEL_W-1:0]       s_counter_select = '0;

    logic                            m_valid;
    logic                            m_ready          = 1'b0;
    logic                            m_show_packet;
    logic                            m_filtered_out;
    logic [pfs_pkg::VALUE_W-1:0]     m_counter_value;

    logic                            cfg_valid        = 1'b0;
    logic                            cfg_ready;
    logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index        = pfs_pkg::CFG_DISPLAY_MASK;
    logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data         = '0;

    packet_filter_statistics u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_frame_len      (s_frame_len),
        .s_dest_mac       (s_dest_mac),
        .s_ether_kind     (s_ether_kind),
        .s_source_ip      (s_source_ip),
        .s_dest_ip        (s_dest_ip),
        .s_ip_protocol    (s_ip_protocol),
        .s_ip_length      (s_ip_length),
        .s_source_port    (s_source_port),
        .s_dest_port      (s_dest_port),
        .s_icmp_kind      (s_icmp_kind),
        .s_counter_select (s_counter_select),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_show_packet    (m_show_packet),
        .m_filtered_out   (m_filtered_out),
        .m_counter_value  (m_counter_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Shadow copy of the block's counters and registers
    logic [pfs_pkg::VALUE_W-1:0] tally [pfs_pkg::NUM_COUNTERS];
    logic [pfs_pkg::MASK_W-1:0]  show_mask;
    logic                        addr_on;
    logic [pfs_pkg::IP_W-1:0]    addr_match;
    logic                        port_on;
    logic [pfs_pkg::PORT_W-1:0]  port_match;

    verdict_t pending_results[$];
    int       mismatches = 0;
    int       cycles     = 0;
    logic     no_gaps    = 1'b0;    // set for one stretch with no idling at all

    // Counts one command into the shadow counters and returns what the block
    // must report for it.
    function automatic verdict_t classify_and_count(input pfs_pkg::pfs_item_t it);
        verdict_t                        v;
        logic [pfs_pkg::FRAME_LEN_W-1:0] len;
        logic                            disp;
        logic                            rejected;
        logic                            addr_ok;
        logic                            port_ok;
        v = '0;
        if (it.command == pfs_pkg::CMD_READ) begin
            // selects 14 and 15 read as zero
            if (it.counter_select < pfs_pkg::NUM_COUNTERS)
                v.value = tally[it.counter_select];
            return v;
        end
        len = (it.frame_len > pfs_pkg::DEF_MAX_FRAME)
              ? pfs_pkg::FRAME_LEN_W'(pfs_pkg::DEF_MAX_FRAME) : it.frame_len;
        addr_ok = !addr_on || it.source_ip == addr_match || it.dest_ip == addr_match;
        port_ok = !port_on || it.source_port == port_match || it.dest_port == port_match;
        rejected = 1'b0;

        tally[pfs_pkg::C_FRAMES] = tally[pfs_pkg::C_FRAMES] + 1;
        tally[pfs_pkg::C_BYTES]  = tally[pfs_pkg::C_BYTES] + len;
        if (len < pfs_pkg::SHORT_LEN)
            tally[pfs_pkg::C_SHORT] = tally[pfs_pkg::C_SHORT] + 1;
        if (len > pfs_pkg::LONG_LEN)
            tally[pfs_pkg::C_LONG] = tally[pfs_pkg::C_LONG] + 1;
        if (it.dest_mac == {pfs_pkg::MAC_W{1'b1}})
            tally[pfs_pkg::C_MACBC] = tally[pfs_pkg::C_MACBC] + 1;

        disp = show_mask[pfs_pkg::M_ETHER];
        if (it.ether_kind == pfs_pkg::ETYPE_ARP) begin
            tally[pfs_pkg::C_ARP] = tally[pfs_pkg::C_ARP] + 1;
            // address mismatch only withholds the arp bit, never rejects
            if (show_mask[pfs_pkg::M_ARP] && addr_ok)
                disp = 1'b1;
        end else if (it.ether_kind == pfs_pkg::ETYPE_IPV4) begin
            tally[pfs_pkg::C_IPPKT]  = tally[pfs_pkg::C_IPPKT] + 1;
            tally[pfs_pkg::C_IPBYTE] = tally[pfs_pkg::C_IPBYTE] + it.ip_length;
            if (it.dest_ip == {pfs_pkg::IP_W{1'b1}})
                tally[pfs_pkg::C_IPBC] = tally[pfs_pkg::C_IPBC] + 1;
            if (!addr_ok) begin
                // dropped before the L4 counters
                rejected = 1'b1;
            end else begin
                if (show_mask[pfs_pkg::M_IP] && !show_mask[pfs_pkg::M_TCP]
                        && !show_mask[pfs_pkg::M_UDP] && !show_mask[pfs_pkg::M_ICMP])
                    disp = 1'b1;
                if (it.ip_protocol == pfs_pkg::PROTO_TCP) begin
                    tally[pfs_pkg::C_TCP] = tally[pfs_pkg::C_TCP] + 1;
                    if (!port_ok)
                        rejected = 1'b1;
                    else if (show_mask[pfs_pkg::M_TCP])
                        disp = 1'b1;
                end else if (it.ip_protocol == pfs_pkg::PROTO_UDP) begin
                    tally[pfs_pkg::C_UDP] = tally[pfs_pkg::C_UDP] + 1;
                    if (!port_ok)
                        rejected = 1'b1;
                    else if (show_mask[pfs_pkg::M_UDP])
                        disp = 1'b1;
                end else if (it.ip_protocol == pfs_pkg::PROTO_ICMP) begin
                    tally[pfs_pkg::C_ICMP] = tally[pfs_pkg::C_ICMP] + 1;
                    if (it.icmp_kind == pfs_pkg::ICMP_REDIR_KIND)
                        tally[pfs_pkg::C_REDIR] = tally[pfs_pkg::C_REDIR] + 1;
                    else if (it.icmp_kind == pfs_pkg::ICMP_UNREACH)
                        tally[pfs_pkg::C_UNREACH] = tally[pfs_pkg::C_UNREACH] + 1;
                    if (show_mask[pfs_pkg::M_ICMP])
                        disp = 1'b1;
                end else if (show_mask[pfs_pkg::M_ALL]) begin
                    disp = 1'b1;
                end
            end
        end else if (show_mask[pfs_pkg::M_ETHER] && show_mask[pfs_pkg::M_ALL]) begin
            disp = 1'b1;
        end

        v.show     = !rejected && (disp || show_mask[pfs_pkg::M_ALL]);
        v.filtered = rejected;
        return v;
    endfunction

    // One input transfer; the random gap comes first so valid is never
    // dropped and raised in the same step.
    task automatic send_item(input pfs_pkg::pfs_item_t it);
        while (!no_gaps && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= it.command;
        s_frame_len      <= it.frame_len;
        s_dest_mac       <= it.dest_mac;
        s_ether_kind     <= it.ether_kind;
        s_source_ip      <= it.source_ip;
        s_dest_ip        <= it.dest_ip;
        s_ip_protocol    <= it.ip_protocol;
        s_ip_length      <= it.ip_length;
        s_source_port    <= it.source_port;
        s_dest_port      <= it.dest_port;
        s_icmp_kind      <= it.icmp_kind;
        s_counter_select <= it.counter_select;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(classify_and_count(it));
    endtask

    task automatic read_counter(input int sel);
        pfs_pkg::pfs_item_t it;
        it = '0;
        it.command        = pfs_pkg::CMD_READ;
        it.counter_select = pfs_pkg::SEL_W'(sel);
        send_item(it);
    endtask

    // Waits until every result is back, then lets the pipeline settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [pfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            pfs_pkg::CFG_DISPLAY_MASK: show_mask  = data[pfs_pkg::MASK_W-1:0];
            pfs_pkg::CFG_ADDR_ON:      addr_on    = data[0];
            pfs_pkg::CFG_ADDR_VALUE:   addr_match = data[pfs_pkg::IP_W-1:0];
            pfs_pkg::CFG_PORT_ON:      port_on    = data[0];
            pfs_pkg::CFG_PORT_VALUE:   port_match = data[pfs_pkg::PORT_W-1:0];
            default: ;
        endcase
    endtask

    // Unused upper bits carry junk; the block must ignore them.
    task automatic apply_config(input logic [pfs_pkg::MASK_W-1:0] mask, input logic aon,
                                input logic [pfs_pkg::IP_W-1:0] aval, input logic pon,
                                input logic [pfs_pkg::PORT_W-1:0] pval);
        logic [pfs_pkg::CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(pfs_pkg::CFG_DISPLAY_MASK,
                  {junk[pfs_pkg::CFG_DATA_W-1:pfs_pkg::MASK_W], mask});
        junk = $urandom;
        write_reg(pfs_pkg::CFG_ADDR_ON, {junk[pfs_pkg::CFG_DATA_W-1:1], aon});
        write_reg(pfs_pkg::CFG_ADDR_VALUE, aval);
        junk = $urandom;
        write_reg(pfs_pkg::CFG_PORT_ON, {junk[pfs_pkg::CFG_DATA_W-1:1], pon});
        junk = $urandom;
        write_reg(pfs_pkg::CFG_PORT_VALUE,
                  {junk[pfs_pkg::CFG_DATA_W-1:pfs_pkg::PORT_W], pval});
        cfg_valid <= 1'b0;
    endtask

    function automatic pfs_pkg::pfs_item_t plain_tcp_packet();
        pfs_pkg::pfs_item_t it;
        it = '0;
        it.command     = pfs_pkg::CMD_PACKET;
        it.frame_len   = 14'd100;
        it.dest_mac    = 48'h00_11_22_33_44_55;
        it.ether_kind  = pfs_pkg::ETYPE_IPV4;
        it.source_ip   = 32'h0a00_0001;
        it.dest_ip     = 32'h0a00_0002;
        it.ip_protocol = pfs_pkg::PROTO_TCP;
        it.ip_length   = 16'd86;
        it.source_port = 16'd1234;
        it.dest_port   = 16'd80;
        return it;
    endfunction

    // Addresses and ports lean on the filter value and the all-ones/zero
    // corners so the filters both pass and reject often.
    function automatic logic [pfs_pkg::IP_W-1:0] pick_ip();
        case ($urandom_range(0, 5))
            0, 1:    return addr_match;
            2:       return {pfs_pkg::IP_W{1'b1}};
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [pfs_pkg::PORT_W-1:0] pick_port();
        case ($urandom_range(0, 5))
            0, 1:    return port_match;
            2:       return {pfs_pkg::PORT_W{1'b1}};
            3:       return '0;
            default: return pfs_pkg::PORT_W'($urandom);
        endcase
    endfunction

    function automatic pfs_pkg::pfs_item_t random_item();
        pfs_pkg::pfs_item_t it;
        logic [63:0] wide;
        it = '0;
        it.command        = ($urandom_range(0, 99) < 25) ? pfs_pkg::CMD_READ
                                                         : pfs_pkg::CMD_PACKET;
        it.counter_select = pfs_pkg::SEL_W'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0: it.frame_len = pfs_pkg::FRAME_LEN_W'($urandom_range(0, 63));
            1: it.frame_len = pfs_pkg::FRAME_LEN_W'($urandom_range(1519,
                                                                   pfs_pkg::DEF_MAX_FRAME));
            2: it.frame_len = pfs_pkg::FRAME_LEN_W'($urandom_range(pfs_pkg::DEF_MAX_FRAME + 1,
                                                                   16383));
            3: it.frame_len = pfs_pkg::FRAME_LEN_W'($urandom_range(62, 66));
            4: it.frame_len = pfs_pkg::FRAME_LEN_W'($urandom_range(1516, 1520));
            default: it.frame_len = pfs_pkg::FRAME_LEN_W'($urandom_range(64, 1518));
        endcase
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    it.dest_mac = {pfs_pkg::MAC_W{1'b1}};
            2:       it.dest_mac = {pfs_pkg::MAC_W{1'b1}}
                                   ^ (48'd1 << $urandom_range(0, pfs_pkg::MAC_W - 1));
            default: it.dest_mac = wide[pfs_pkg::MAC_W-1:0];
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.ether_kind = pfs_pkg::ETYPE_IPV4;
            4, 5:       it.ether_kind = pfs_pkg::ETYPE_ARP;
            6:          it.ether_kind = pfs_pkg::ETYPE_ARP
                                        ^ (16'd1 << $urandom_range(0, pfs_pkg::ETYPE_W - 1));
            default:    it.ether_kind = pfs_pkg::ETYPE_W'($urandom);
        endcase
        it.source_ip = pick_ip();
        it.dest_ip   = pick_ip();
        case ($urandom_range(0, 9))
            0, 1, 2: it.ip_protocol = pfs_pkg::PROTO_TCP;
            3, 4:    it.ip_protocol = pfs_pkg::PROTO_UDP;
            5, 6:    it.ip_protocol = pfs_pkg::PROTO_ICMP;
            default: it.ip_protocol = pfs_pkg::PROTO_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       it.icmp_kind = pfs_pkg::ICMP_REDIR_KIND;
            1:       it.icmp_kind = pfs_pkg::ICMP_UNREACH;
            default: it.icmp_kind = pfs_pkg::ICMP_W'($urandom);
        endcase
        it.ip_length   = pfs_pkg::LEN_W'($urandom);
        it.source_port = pick_port();
        it.dest_port   = pick_port();
        return it;
    endfunction

    // Result channel backpressure
    always @(posedge aclk)
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 25);

    // Result checker: oldest expectation first
    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_show_packet !== want.show) begin
                    $error("m_show_packet: expected %0d, got %0d", want.show, m_show_packet);
                    mismatches++;
                end
                if (m_filtered_out !== want.filtered) begin
                    $error("m_filtered_out: expected %0d, got %0d",
                           want.filtered, m_filtered_out);
                    mismatches++;
                end
                if (m_counter_value !== want.value) begin
                    $error("m_counter_value: expected %0h, got %0h",
                           want.value, m_counter_value);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sampled counters read back zero after reset, as do the unused selects.
    task automatic test_reset_state();
        read_counter(pfs_pkg::C_FRAMES);
        read_counter(pfs_pkg::C_IPBYTE);
        read_counter(pfs_pkg::C_ARP);
        read_counter(pfs_pkg::NUM_COUNTERS);
        read_counter(15);
        drain_results();
    endtask

    // Short/long boundaries, clamp of oversized frames, MAC broadcast.
    task automatic test_frame_sizes();
        pfs_pkg::pfs_item_t it;
        apply_config(7'b000_0001, 1'b0, '0, 1'b0, '0);
        it = plain_tcp_packet();
        it.frame_len = '0;
        send_item(it);
        it.frame_len = 14'd63;
        it.dest_mac  = {pfs_pkg::MAC_W{1'b1}};
        send_item(it);
        it.frame_len = 14'd1518;
        send_item(it);
        it.frame_len = 14'd1519;
        it.dest_mac  = 48'hffff_ffff_fffe;
        send_item(it);
        it.frame_len = {pfs_pkg::FRAME_LEN_W{1'b1}};     // counts as MAX_FRAME bytes
        send_item(it);
        read_counter(pfs_pkg::C_BYTES);
        drain_results();
    endtask

    // One packet down each classification branch.
    task automatic test_protocols();
        pfs_pkg::pfs_item_t it;
        apply_config(7'h7f, 1'b0, '0, 1'b0, '0);
        it = plain_tcp_packet();
        send_item(it);
        it.ip_protocol = pfs_pkg::PROTO_UDP;
        send_item(it);
        it.ip_protocol = pfs_pkg::PROTO_ICMP;
        it.icmp_kind   = pfs_pkg::ICMP_REDIR_KIND;
        send_item(it);
        it.icmp_kind   = pfs_pkg::ICMP_UNREACH;
        send_item(it);
        it.ip_protocol = 8'd50;
        it.dest_ip     = {pfs_pkg::IP_W{1'b1}};
        it.ip_length   = {pfs_pkg::LEN_W{1'b1}};
        send_item(it);
        it.ether_kind  = pfs_pkg::ETYPE_ARP;
        send_item(it);
        it.ether_kind  = 16'h86dd;
        send_item(it);
        drain_results();
    endtask

    // Address reject, ARP mismatch (shown only via other bits), port reject.
    task automatic test_filters();
        pfs_pkg::pfs_item_t it;
        apply_config(7'b001_1110, 1'b1, 32'h0a00_0002, 1'b1, 16'd80);
        it = plain_tcp_packet();
        it.dest_ip = 32'h0a00_0009;
        send_item(it);
        it.ether_kind = pfs_pkg::ETYPE_ARP;
        send_item(it);
        it = plain_tcp_packet();
        it.dest_port = 16'd81;
        send_item(it);
        it.ip_protocol = pfs_pkg::PROTO_UDP;
        it.source_port = 16'd80;
        send_item(it);
        read_counter(pfs_pkg::C_TCP);
        drain_results();
    endtask

    // Randomized traffic over a series of settings, extremes first.
    task automatic test_random_traffic();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: apply_config(7'h7f, 1'b1, {pfs_pkg::IP_W{1'b1}}, 1'b1,
                                {pfs_pkg::PORT_W{1'b1}});
                1: apply_config('0, 1'b0, '0, 1'b0, '0);
                2: apply_config('0, 1'b1, '0, 1'b1, '0);
                default: apply_config(pfs_pkg::MASK_W'($urandom), 1'($urandom), $urandom,
                                      1'($urandom), pfs_pkg::PORT_W'($urandom));
            endcase
            no_gaps = (ph == 5);
            repeat (PHASE_ITEMS)
                send_item(random_item());
            drain_results();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < pfs_pkg::NUM_COUNTERS; i++)
            tally[i] = '0;
        show_mask  = '0;
        addr_on    = 1'b0;
        addr_match = '0;
        port_on    = 1'b0;
        port_match = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_frame_sizes();
        test_protocols();
        test_filters();
        test_random_traffic();

        drain_results();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
